>>> hdl/aabbcir_pkg.sv
// ----------------------------------------------------------------------------
// aabbcir_pkg: shared types and constants of the collision resolver
// Beat formats, the job record passed from front to back, and saturation.
// ----------------------------------------------------------------------------
package aabbcir_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int BNC_BITS  = FRAC_BITS + 1;
	localparam int K_BITS    = FRAC_BITS + 2;
	localparam int MAG_BITS  = WORD_BITS + 1;
	localparam int PROD_BITS = MAG_BITS + K_BITS;
	localparam int NUM_BITS  = PROD_BITS + WORD_BITS;
	localparam int REM_BITS  = WORD_BITS + 1;
	localparam int CNT_BITS  = $clog2(NUM_BITS);

	typedef struct packed {
		logic                        second_body;
		logic signed [WORD_BITS-1:0] box_min_x;
		logic signed [WORD_BITS-1:0] box_max_x;
		logic signed [WORD_BITS-1:0] box_min_y;
		logic signed [WORD_BITS-1:0] box_max_y;
		logic signed [WORD_BITS-1:0] vel_x;
		logic signed [WORD_BITS-1:0] vel_y;
		logic [WORD_BITS-1:0]        body_mass;
		logic [BNC_BITS-1:0]         bounce;
		logic                        fixed_body;
	} in_beat_t;

	typedef struct packed {
		logic                        which_body;
		logic                        axis;
		logic signed [WORD_BITS-1:0] position_shift;
		logic                        velocity_valid;
		logic signed [WORD_BITS-1:0] new_velocity;
		logic                        last;
	} out_beat_t;

	typedef struct packed {
		logic                        axis;
		logic                        both;
		logic signed [WORD_BITS-1:0] shift_a;
		logic signed [WORD_BITS-1:0] shift_b;
		logic signed [WORD_BITS-1:0] vel_a;
		logic signed [WORD_BITS-1:0] vel_b;
		logic                        rel_neg;
		logic [MAG_BITS-1:0]         rel_mag;
		logic [K_BITS-1:0]           k;
		logic [WORD_BITS-1:0]        mass_a;
		logic [WORD_BITS-1:0]        mass_b;
		logic [WORD_BITS:0]          den;
	} job_t;

	// Clamp a value to the signed word range.
	function automatic logic signed [WORD_BITS-1:0] sat_word(
		input logic signed [WORD_BITS+2:0] v);
		logic signed [WORD_BITS+2:0] hi;
		logic signed [WORD_BITS+2:0] lo;
		hi = {4'b0000, {(WORD_BITS-1){1'b1}}};
		lo = {4'b1111, {(WORD_BITS-1){1'b0}}};
		if (v > hi) begin
			sat_word = hi[WORD_BITS-1:0];
		end else if (v < lo) begin
			sat_word = lo[WORD_BITS-1:0];
		end else begin
			sat_word = v[WORD_BITS-1:0];
		end
	endfunction

endpackage

>>> hdl/aabbcir_jobq.sv
// ----------------------------------------------------------------------------
// aabbcir_jobq: two-entry job queue
// Decouples the classifying front from the impulse back end.
// ----------------------------------------------------------------------------
module aabbcir_jobq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  aabbcir_pkg::job_t  din,
	output logic               full,
	input  logic               pop,
	output aabbcir_pkg::job_t  dout,
	output logic               empty
);

	aabbcir_pkg::job_t mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

>>> hdl/aabbcir_front.sv
// ----------------------------------------------------------------------------
// aabbcir_front: body intake and contact classification
// Holds body A, forms overlaps on body B and builds one job per pair.
// ----------------------------------------------------------------------------
module aabbcir_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  aabbcir_pkg::in_beat_t body,
	output logic                  job_push,
	output aabbcir_pkg::job_t     job,
	input  logic                  job_full
);

	localparam int W = aabbcir_pkg::WORD_BITS;
	localparam int F = aabbcir_pkg::FRAC_BITS;
	localparam int B = aabbcir_pkg::BNC_BITS;

	logic signed [W-1:0] held_min_x_q, held_max_x_q, held_min_y_q, held_max_y_q;
	logic signed [W-1:0] held_vel_x_q, held_vel_y_q;
	logic [W-1:0]        held_mass_q;
	logic [B-1:0]        held_bounce_q;
	logic                held_static_q;

	logic                valid_s1;
	logic signed [W:0]   ox_s1, oy_s1;
	logic                less_x_s1, less_y_s1;
	logic signed [W-1:0] va_x_s1, va_y_s1, vb_x_s1, vb_y_s1;
	logic [W-1:0]        ma_s1, mb_s1;
	logic [B-1:0]        ba_s1, bb_s1;
	logic                sta_s1, stb_s1;

	logic                accept;
	logic signed [W-1:0] lo_x, hi_x, lo_y, hi_y;
	logic signed [W:0]   ov, ov_adj, half, sa, neg_sa, rel;
	logic                axis;
	logic signed [W-1:0] va, vb;
	logic [B:0]          bsum;

	assign full     = valid_s1 && job_full;
	assign accept   = push && !full;
	assign job_push = valid_s1 && !job_full;

	// Overlap of the two boxes on each axis, from the held box and the incoming one.
	always_comb begin
		hi_x = (held_max_x_q < body.box_max_x) ? held_max_x_q : body.box_max_x;
		lo_x = (held_min_x_q > body.box_min_x) ? held_min_x_q : body.box_min_x;
		hi_y = (held_max_y_q < body.box_max_y) ? held_max_y_q : body.box_max_y;
		lo_y = (held_min_y_q > body.box_min_y) ? held_min_y_q : body.box_min_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_min_x_q  <= '0;
			held_max_x_q  <= '0;
			held_min_y_q  <= '0;
			held_max_y_q  <= '0;
			held_vel_x_q  <= '0;
			held_vel_y_q  <= '0;
			held_mass_q   <= '0;
			held_bounce_q <= '0;
			held_static_q <= 1'b0;
			valid_s1      <= 1'b0;
		end else begin
			if (accept && !body.second_body) begin
				held_min_x_q  <= body.box_min_x;
				held_max_x_q  <= body.box_max_x;
				held_min_y_q  <= body.box_min_y;
				held_max_y_q  <= body.box_max_y;
				held_vel_x_q  <= body.vel_x;
				held_vel_y_q  <= body.vel_y;
				held_mass_q   <= body.body_mass;
				held_bounce_q <= body.bounce;
				held_static_q <= body.fixed_body;
			end
			if (accept && body.second_body) begin
				valid_s1 <= 1'b1;
			end else if (job_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && body.second_body) begin
			ox_s1     <= {hi_x[W-1], hi_x} - {lo_x[W-1], lo_x};
			oy_s1     <= {hi_y[W-1], hi_y} - {lo_y[W-1], lo_y};
			less_x_s1 <= held_min_x_q < body.box_min_x;
			less_y_s1 <= held_min_y_q < body.box_min_y;
			va_x_s1   <= held_vel_x_q;
			va_y_s1   <= held_vel_y_q;
			vb_x_s1   <= body.vel_x;
			vb_y_s1   <= body.vel_y;
			ma_s1     <= held_mass_q;
			mb_s1     <= body.body_mass;
			ba_s1     <= held_bounce_q;
			bb_s1     <= body.bounce;
			sta_s1    <= held_static_q;
			stb_s1    <= body.fixed_body;
		end
	end

	// Axis choice, half-overlap shifts and the operands of the impulse.
	always_comb begin
		axis   = !(ox_s1 < oy_s1);
		ov     = axis ? oy_s1 : ox_s1;
		ov_adj = ov + {{W{1'b0}}, ov[W]};
		half   = ov_adj >>> 1;
		sa     = (axis ? less_y_s1 : less_x_s1) ? -half : half;
		neg_sa = -sa;
		va     = axis ? va_y_s1 : va_x_s1;
		vb     = axis ? vb_y_s1 : vb_x_s1;
		rel    = {va[W-1], va} - {vb[W-1], vb};
		bsum   = {1'b0, ba_s1} + {1'b0, bb_s1};

		job.axis    = axis;
		job.both    = !sta_s1 && !stb_s1;
		job.shift_a = sta_s1 ? '0 : aabbcir_pkg::sat_word({{2{sa[W]}}, sa});
		job.shift_b = stb_s1 ? '0 : aabbcir_pkg::sat_word({{2{neg_sa[W]}}, neg_sa});
		job.vel_a   = va;
		job.vel_b   = vb;
		job.rel_neg = rel[W];
		job.rel_mag = rel[W] ? $unsigned(-rel) : $unsigned(rel);
		job.k       = {2'b01, {F{1'b0}}} + {1'b0, bsum[B:1]};
		job.mass_a  = ma_s1;
		job.mass_b  = mb_s1;
		job.den     = {1'b0, ma_s1} + {1'b0, mb_s1};
	end

endmodule

>>> hdl/aabbcir_back.sv
// ----------------------------------------------------------------------------
// aabbcir_back: impulse sequencer and result buffer
// For a moving pair multiplies out the impulse numerators and divides both by
// the mass sum one quotient bit per cycle; then writes the pair of results.
// ----------------------------------------------------------------------------
module aabbcir_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   job_empty,
	input  aabbcir_pkg::job_t      job,
	output logic                   job_pop,
	output logic                   empty,
	input  logic                   pop,
	output aabbcir_pkg::out_beat_t result
);

	localparam int W    = aabbcir_pkg::WORD_BITS;
	localparam int F    = aabbcir_pkg::FRAC_BITS;
	localparam int PB   = aabbcir_pkg::PROD_BITS;
	localparam int NB   = aabbcir_pkg::NUM_BITS;
	localparam int RB   = aabbcir_pkg::REM_BITS;
	localparam int CB   = aabbcir_pkg::CNT_BITS;
	localparam int MB   = aabbcir_pkg::MAG_BITS;
	localparam int KB   = aabbcir_pkg::K_BITS;
	localparam int HB   = PB - W;
	localparam int QB   = NB - F;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_MUL2 = 3'd2;
	localparam logic [2:0] ST_MUL3 = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	localparam logic [QB-1:0] CAP = {{(QB-W-2){1'b0}}, 1'b1, {(W+1){1'b0}}};

	logic [2:0]              state_q;
	aabbcir_pkg::job_t       job_q;
	logic [PB-1:0]           prod_q;
	logic [2*W-1:0]          lo_a_q, lo_b_q;
	logic [NB-1:0]           num_a_q, num_b_q;
	logic [RB-1:0]           rem_a_q, rem_b_q;
	logic [CB-1:0]           cnt_q;
	aabbcir_pkg::out_beat_t  res0_q, res1_q;
	logic [1:0]              res_cnt_q;

	logic [RB:0]             trial_a, trial_b, diff_a, diff_b;
	logic                    ge_a, ge_b;
	logic [QB-1:0]           qs_a, qs_b;
	logic [W+1:0]            mag_a, mag_b;
	logic signed [W+2:0]     va_x, vb_x, da_x, db_x, nva, nvb;
	logic [HB+W-1:0]         hi_a, hi_b;
	aabbcir_pkg::out_beat_t  beat_a, beat_b;
	logic                    fin_write;

	assign job_pop   = (state_q == ST_IDLE) && !job_empty;
	assign empty     = (res_cnt_q == 2'd0);
	assign result    = res0_q;
	assign fin_write = (state_q == ST_FIN) && (res_cnt_q == 2'd0);

	// One restoring step on each lane.
	always_comb begin
		trial_a = {rem_a_q, num_a_q[NB-1]};
		trial_b = {rem_b_q, num_b_q[NB-1]};
		ge_a    = trial_a >= {1'b0, job_q.den};
		ge_b    = trial_b >= {1'b0, job_q.den};
		diff_a  = ge_a ? trial_a - {1'b0, job_q.den} : trial_a;
		diff_b  = ge_b ? trial_b - {1'b0, job_q.den} : trial_b;
		hi_a    = prod_q[PB-1:W] * job_q.mass_b;
		hi_b    = prod_q[PB-1:W] * job_q.mass_a;
	end

	// Scale, cap and apply the two velocity changes.
	always_comb begin
		qs_a  = num_a_q[NB-1:F];
		qs_b  = num_b_q[NB-1:F];
		mag_a = (job_q.den == '0) ? '0 : ((qs_a > CAP) ? CAP[W+1:0] : qs_a[W+1:0]);
		mag_b = (job_q.den == '0) ? '0 : ((qs_b > CAP) ? CAP[W+1:0] : qs_b[W+1:0]);
		va_x  = {{3{job_q.vel_a[W-1]}}, job_q.vel_a};
		vb_x  = {{3{job_q.vel_b[W-1]}}, job_q.vel_b};
		da_x  = {1'b0, mag_a};
		db_x  = {1'b0, mag_b};
		nva   = job_q.rel_neg ? va_x + da_x : va_x - da_x;
		nvb   = job_q.rel_neg ? vb_x - db_x : vb_x + db_x;

		beat_a.which_body     = 1'b0;
		beat_a.axis           = job_q.axis;
		beat_a.position_shift = job_q.shift_a;
		beat_a.velocity_valid = job_q.both;
		beat_a.new_velocity   = job_q.both ? aabbcir_pkg::sat_word(nva) : '0;
		beat_a.last           = 1'b0;
		beat_b.which_body     = 1'b1;
		beat_b.axis           = job_q.axis;
		beat_b.position_shift = job_q.shift_b;
		beat_b.velocity_valid = job_q.both;
		beat_b.new_velocity   = job_q.both ? aabbcir_pkg::sat_word(nvb) : '0;
		beat_b.last           = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			res_cnt_q <= 2'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						state_q <= job.both ? ST_MUL1 : ST_FIN;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: begin
					state_q <= ST_DIV;
					cnt_q   <= CB'(NB - 1);
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_FIN: begin
					if (fin_write) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (fin_write) begin
				res_cnt_q <= 2'd2;
			end else if (pop && !empty) begin
				res_cnt_q <= res_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		if (state_q == ST_MUL1) begin
			prod_q <= {{(PB-MB){1'b0}}, job_q.rel_mag} * {{(PB-KB){1'b0}}, job_q.k};
		end
		if (state_q == ST_MUL2) begin
			lo_a_q <= prod_q[W-1:0] * job_q.mass_b;
			lo_b_q <= prod_q[W-1:0] * job_q.mass_a;
		end
		if (state_q == ST_MUL3) begin
			num_a_q <= {hi_a, {W{1'b0}}} + {{(NB-2*W){1'b0}}, lo_a_q};
			num_b_q <= {hi_b, {W{1'b0}}} + {{(NB-2*W){1'b0}}, lo_b_q};
			rem_a_q <= '0;
			rem_b_q <= '0;
		end
		if (state_q == ST_DIV) begin
			rem_a_q <= diff_a[RB-1:0];
			rem_b_q <= diff_b[RB-1:0];
			num_a_q <= {num_a_q[NB-2:0], ge_a};
			num_b_q <= {num_b_q[NB-2:0], ge_b};
		end
		if (fin_write) begin
			res0_q <= beat_a;
			res1_q <= beat_b;
		end else if (pop && !empty) begin
			res0_q <= res1_q;
		end
	end

endmodule

>>> hdl/aabb_collision_impulse_resolver_core.sv
// ----------------------------------------------------------------------------
// aabb_collision_impulse_resolver_core: AABB contact resolver with impulse
// Resolves a pair of bodies along the axis of smaller overlap, in Q16.16.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Beat
//  body      in         push / full                 in_beat_t, one body
//  result    out        pop / empty                 out_beat_t, two per pair
//
// A body A beat only updates the held body. A body B beat passes one
// classification stage and then waits in a two-entry job queue. The back end
// sends a static pair straight to the result write; a moving pair passes
// three multiply states and NUM_BITS (83) divide steps in the
// one-bit-per-cycle divider that runs both quotients side by side.
// Reset clears the held body to zero and empties every queue. The back end
// writes a pair of results only into an empty result buffer, so a stalled
// reader holds it there while the front keeps taking bodies until the job
// queue fills.
module aabb_collision_impulse_resolver_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  aabbcir_pkg::in_beat_t  body,
	output logic                   empty,
	input  logic                   pop,
	output aabbcir_pkg::out_beat_t result
);

	// Jobs travel from the front to the back end through a short queue so each
	// side can stall on its own.
	logic              jobq_push;
	logic              jobq_full;
	logic              jobq_pop;
	logic              jobq_empty;
	aabbcir_pkg::job_t jobq_din;
	aabbcir_pkg::job_t jobq_dout;

	aabbcir_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.body     (body),
		.job_push (jobq_push),
		.job      (jobq_din),
		.job_full (jobq_full)
	);

	aabbcir_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (jobq_push),
		.din    (jobq_din),
		.full   (jobq_full),
		.pop    (jobq_pop),
		.dout   (jobq_dout),
		.empty  (jobq_empty)
	);

	// The back end sequences the impulse math and buffers the result pair.
	aabbcir_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (jobq_empty),
		.job       (jobq_dout),
		.job_pop   (jobq_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

`ifndef NO_ASSERTIONS
	// The front never hands a job to a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) jobq_push |-> !jobq_full)
		else $error("job pushed into a full queue");

	// A velocity that was not changed reads as zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.velocity_valid) |-> (result.new_velocity == '0))
		else $error("new velocity set without an impulse");

	// Taking body A's result leaves body B's result waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !result.last) |=> (!empty && result.last))
		else $error("second result of a pair missing");
`endif

endmodule

>>> sim/aabb_collision_impulse_resolver_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_collision_impulse_resolver_core_tb: self-checking bench of the resolver
// Feeds body pairs through the queue-style input, predicts the two results of
// every resolved pair in 128-bit arithmetic and checks each popped beat.
// ----------------------------------------------------------------------------
module aabb_collision_impulse_resolver_core_tb;

	localparam int IDLE_MAX    = 11;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 200;
	localparam int HOLD_CYCLES = 600;

	logic                   clk;
	logic                   arst_n;
	logic                   push;
	logic                   full;
	aabbcir_pkg::in_beat_t  body;
	logic                   empty;
	logic                   pop;
	aabbcir_pkg::out_beat_t result;

	aabb_collision_impulse_resolver_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .body(body),
		.empty(empty), .pop(pop), .result(result)
	);

	// Stimulus waiting to be offered, and results the predictor expects.
	aabbcir_pkg::in_beat_t  body_queue[$];
	aabbcir_pkg::out_beat_t expected_results[$];

	// Copy of body A as the block holds it.
	aabbcir_pkg::in_beat_t held_a = '0;

	int  error_count = 0;
	int  cycle_count = 0;
	bit  hold_req    = 1'b0;  // long reader stall requested by the stimulus
	bit  hold_taken;
	int  reader_hold;         // cycles left in the long reader stall
	bit  sender_sync = 1'b0;  // sender waits for the result queue to drain

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	function automatic logic signed [aabbcir_pkg::WORD_BITS-1:0] clamp_word(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[aabbcir_pkg::WORD_BITS-1:0];
	endfunction

	// Magnitude of one body's velocity change, capped at twice the word range.
	function automatic longint impulse_size(logic [63:0] rel_mag, logic [63:0] k,
		logic [63:0] other_mass, logic [63:0] mass_sum);
		logic [127:0] num;
		logic [127:0] quo;
		if (mass_sum == 0) return 0;
		num = 128'(rel_mag) * 128'(k) * 128'(other_mass);
		quo = (num / 128'(mass_sum)) >> aabbcir_pkg::FRAC_BITS;
		if (quo > (128'd1 << (aabbcir_pkg::WORD_BITS + 1)))
			return longint'(64'd1 << (aabbcir_pkg::WORD_BITS + 1));
		return longint'(quo[63:0]);
	endfunction

	// Accepted body: A updates the held copy, B queues the pair's two results.
	task automatic predict_pair(aabbcir_pkg::in_beat_t b);
		longint ox, oy, ov, half, sa, va, vb, rel, da, db;
		longint amin[2], amax[2], bmin[2], bmax[2];
		logic [63:0] relm, k, msum;
		bit ax, both;
		aabbcir_pkg::out_beat_t ra, rb;
		if (!b.second_body) begin
			held_a = b;
			return;
		end
		amin[0] = held_a.box_min_x; amax[0] = held_a.box_max_x;
		amin[1] = held_a.box_min_y; amax[1] = held_a.box_max_y;
		bmin[0] = b.box_min_x; bmax[0] = b.box_max_x;
		bmin[1] = b.box_min_y; bmax[1] = b.box_max_y;
		ox = (amax[0] < bmax[0] ? amax[0] : bmax[0]) - (amin[0] > bmin[0] ? amin[0] : bmin[0]);
		oy = (amax[1] < bmax[1] ? amax[1] : bmax[1]) - (amin[1] > bmin[1] ? amin[1] : bmin[1]);
		ax = (ox < oy) ? 1'b0 : 1'b1;
		ov = ax ? oy : ox;
		half = ov / 2;
		sa = (amin[ax] < bmin[ax]) ? -half : half;
		both = !held_a.fixed_body && !b.fixed_body;
		ra = '0;
		rb = '0;
		ra.axis = ax;
		rb.axis = ax;
		rb.which_body = 1'b1;
		rb.last = 1'b1;
		ra.position_shift = held_a.fixed_body ? '0 : clamp_word(sa);
		rb.position_shift = b.fixed_body ? '0 : clamp_word(-sa);
		ra.velocity_valid = both;
		rb.velocity_valid = both;
		if (both) begin
			va = ax ? held_a.vel_y : held_a.vel_x;
			vb = ax ? b.vel_y : b.vel_x;
			rel = va - vb;
			relm = rel < 0 ? -rel : rel;
			k = (64'd1 << aabbcir_pkg::FRAC_BITS)
				+ ((64'(held_a.bounce) + 64'(b.bounce)) >> 1);
			msum = 64'(held_a.body_mass) + 64'(b.body_mass);
			da = impulse_size(relm, k, b.body_mass, msum);
			db = impulse_size(relm, k, held_a.body_mass, msum);
			if (rel < 0) begin
				da = -da;
				db = -db;
			end
			ra.new_velocity = clamp_word(va - da);
			rb.new_velocity = clamp_word(vb + db);
		end
		expected_results.push_back(ra);
		expected_results.push_back(rb);
	endtask

	function automatic logic [31:0] rand_edge();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	// A random body; most pairs overlap at modest coordinates so that both
	// axes and both push directions occur, the rest use the full range.
	function automatic aabbcir_pkg::in_beat_t rand_body(bit second, bit wild);
		aabbcir_pkg::in_beat_t b;
		int c;
		b.second_body = second;
		if (wild) begin
			b.box_min_x = rand_edge(); b.box_max_x = rand_edge();
			b.box_min_y = rand_edge(); b.box_max_y = rand_edge();
			b.vel_x = rand_edge(); b.vel_y = rand_edge();
			b.body_mass = ($urandom_range(0, 3) == 0) ? 32'hffffffff : $urandom;
			b.bounce = 17'($urandom_range(0, 131071));
		end else begin
			c = $urandom_range(0, 1 << 22);
			b.box_min_x = c - $urandom_range(0, 1 << 20);
			b.box_max_x = b.box_min_x + $urandom_range(1, 1 << 21);
			c = $urandom_range(0, 1 << 22);
			b.box_min_y = c - $urandom_range(0, 1 << 20);
			b.box_max_y = b.box_min_y + $urandom_range(1, 1 << 21);
			b.vel_x = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
			b.vel_y = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
			b.body_mass = $urandom_range(1, 1 << 22);
			b.bounce = 17'($urandom_range(0, 65536));
		end
		if (b.body_mass == 0) b.body_mass = 1;
		b.fixed_body = ($urandom_range(0, 4) == 0);
		return b;
	endfunction

	function automatic aabbcir_pkg::in_beat_t make_body(bit second, int x0, int x1,
		int y0, int y1, int vx, int vy, logic [31:0] m, logic [16:0] e, bit st);
		aabbcir_pkg::in_beat_t b;
		b.second_body = second;
		b.box_min_x = x0; b.box_max_x = x1; b.box_min_y = y0; b.box_max_y = y1;
		b.vel_x = vx; b.vel_y = vy; b.body_mass = m; b.bounce = e; b.fixed_body = st;
		return b;
	endfunction

	// Driver: one beat at a time, with a random gap before each.
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			body <= '0;
			send_gap <= 0;
		end else begin
			if (push && !full) begin
				predict_pair(body);
				void'(body_queue.pop_front());
			end
			if (push && full) begin
				// Keep offering the same beat.
			end else if (send_gap > 0) begin
				push <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (sender_sync && (body_queue.size() == 0 || !(push && !full))
				&& (expected_results.size() != 0 || body_queue.size() == 0)) begin
				push <= 1'b0;
			end else if (body_queue.size() > 0) begin
				push <= 1'b1;
				body <= body_queue[0];
				send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, IDLE_MAX);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Long reader stall, counted in cycles once the stimulus asks for it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reader_hold <= 0;
			hold_taken <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			reader_hold <= HOLD_CYCLES;
			hold_taken <= 1'b1;
		end else if (reader_hold > 0) begin
			reader_hold <= reader_hold - 1;
		end
	end

	// Monitor and reader: compares each popped beat with the oldest expectation.
	int pop_gap;
	int next_gap;
	always @(posedge clk or negedge arst_n) begin
		aabbcir_pkg::out_beat_t want;
		if (!arst_n) begin
			pop <= 1'b0;
			pop_gap <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: %h", result);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (result.which_body !== want.which_body) begin
						$error("which_body: expected %0d, got %0d", want.which_body,
							result.which_body);
						error_count++;
					end
					if (result.axis !== want.axis) begin
						$error("axis: expected %0d, got %0d", want.axis, result.axis);
						error_count++;
					end
					if (result.position_shift !== want.position_shift) begin
						$error("position_shift: expected %0d, got %0d",
							want.position_shift, result.position_shift);
						error_count++;
					end
					if (result.velocity_valid !== want.velocity_valid) begin
						$error("velocity_valid: expected %0d, got %0d",
							want.velocity_valid, result.velocity_valid);
						error_count++;
					end
					if (result.new_velocity !== want.new_velocity) begin
						$error("new_velocity: expected %0d, got %0d",
							want.new_velocity, result.new_velocity);
						error_count++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, result.last);
						error_count++;
					end
				end
			end
			if (reader_hold > 0) begin
				pop <= 1'b0;
			end else if (pop_gap > 0) begin
				pop <= 1'b0;
				pop_gap <= pop_gap - 1;
			end else if (pop && !empty) begin
				// A beat was just taken: draw the idle cycles before the next one.
				next_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, IDLE_MAX);
				if (next_gap == 0) begin
					pop <= 1'b1;
				end else begin
					pop <= 1'b0;
					pop_gap <= next_gap - 1;
				end
			end else if (!pop) begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int n;
		aabbcir_pkg::in_beat_t b;
		bit stall_started;
		bit sync_done;
		stall_started = 1'b0;
		sync_done = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Body B with nothing held yet: uses the reset state, masses sum to B's.
		body_queue.push_back(make_body(1, 10, 20, 10, 20, 5, -5, 32'h10000, 17'h10000, 0));
		// Both masses zero is never driven here (the bench keeps mass nonzero), but
		// an all-zero held body after reset with mass 0x10000 on B covers the edge.
		// Overlap on x smaller, A left of B.
		body_queue.push_back(make_body(0, 0, 32'h30000, 0, 32'ha0000, 32'h20000, 0,
			32'h10000, 17'h8000, 0));
		body_queue.push_back(make_body(1, 32'h20000, 32'h50000, 0, 32'ha0000,
			-32'sh10000, 32'h1000, 32'h20000, 17'h10000, 0));
		// Tie in overlap goes to y; A right of B.
		body_queue.push_back(make_body(0, 10, 30, 10, 30, -7, 9, 1, 0, 0));
		body_queue.push_back(make_body(1, 0, 20, 0, 20, 3, -3, 32'hffffffff, 17'h1ffff, 0));
		// Static A, then static B, then both static.
		body_queue.push_back(make_body(0, 0, 100, 0, 100, 1, 1, 5, 5, 1));
		body_queue.push_back(make_body(1, 50, 150, 90, 200, 2, 2, 5, 5, 0));
		body_queue.push_back(make_body(0, 0, 100, 0, 100, 1, 1, 5, 5, 0));
		body_queue.push_back(make_body(1, 50, 150, 90, 200, 2, 2, 5, 5, 1));
		body_queue.push_back(make_body(0, 0, 100, 0, 100, 1, 1, 5, 5, 1));
		body_queue.push_back(make_body(1, 50, 150, 90, 200, 2, 2, 5, 5, 1));
		// Separated boxes: negative overlap.
		body_queue.push_back(make_body(0, 0, 10, 0, 10, 100, 0, 7, 3, 0));
		body_queue.push_back(make_body(1, 500, 600, 300, 310, -100, 0, 9, 4, 0));
		// Extremes: saturating shifts and velocities.
		body_queue.push_back(make_body(0, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffffff, 17'h1ffff, 0));
		body_queue.push_back(make_body(1, 32'h7fffffff, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h80000000, 1, 17'h1ffff, 0));
		body_queue.push_back(make_body(0, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h80000000, 0, 1, 0, 0));
		body_queue.push_back(make_body(1, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'hffffffff, 17'h1ffff, 0));

		// Random part: mostly well-formed A/B pairs, some lone or repeated beats.
		for (n = 0; n < 630; n++) begin
			case ($urandom_range(0, 9))
				0: body_queue.push_back(rand_body($urandom_range(0, 1), 1));
				1: body_queue.push_back(rand_body(1, 0));
				default: begin
					b = rand_body(0, $urandom_range(0, 5) == 0);
					body_queue.push_back(b);
					body_queue.push_back(rand_body(1, $urandom_range(0, 5) == 0));
					n++;
				end
			endcase
			if (!stall_started && n >= 200) begin
				// Long reader stall while the sender keeps offering beats.
				wait (body_queue.size() < 40);
				hold_req = 1'b1;
				stall_started = 1'b1;
			end
			if (!sync_done && n >= 400) begin
				// Sender pauses until every expected result has come.
				wait (body_queue.size() == 0);
				sender_sync = 1;
				wait (expected_results.size() == 0 && !push);
				sender_sync = 0;
				sync_done = 1'b1;
			end
		end

		wait (body_queue.size() == 0 && !push);
		wait (expected_results.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/aabbcir_pkg.sv
hdl/aabbcir_jobq.sv
hdl/aabbcir_front.sv
hdl/aabbcir_back.sv
hdl/aabb_collision_impulse_resolver_core.sv
sim/aabb_collision_impulse_resolver_core_tb.sv
